[hdl/sac_pkg.sv]
// sac_pkg: shared types, widths, reset values and codes for the stick axis conditioner.
// No dependencies.
`timescale 1ns / 1ps
package sac_pkg;

    localparam int DEF_CHANNEL_COUNT = 4;
    localparam int STORE_MAX   = 4;
    localparam int CHAN_IDX_W  = 2;

    localparam int SMP_W   = 12;
    localparam int MV_W    = 16;
    localparam int PCT_W   = 8;
    localparam int THR_W   = 7;
    localparam int KEY_W   = 2;
    localparam int QUOT_W  = 7;
    localparam int NUM_W   = 19;
    localparam int DIV_CNT_W = $clog2(QUOT_W);
    localparam int PCT_FULL  = 100;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam int S_TDATA_W = 56;
    localparam int S_KEY_LSB = STORE_MAX * SMP_W;
    localparam int M_USED_W  = PCT_W + THR_W + KEY_W + STORE_MAX * (SMP_W + MV_W);
    localparam int M_TDATA_W = 136;
    localparam int M_PAD_W   = M_TDATA_W - M_USED_W;

    localparam logic [MV_W-1:0]  RST_REF_MV   = 16'd3300;
    localparam logic [SMP_W-1:0] RST_PITCH_LO = 12'd0;
    localparam logic [SMP_W-1:0] RST_PITCH_MID = 12'd2048;
    localparam logic [SMP_W-1:0] RST_PITCH_HI = 12'd4095;
    localparam logic [SMP_W-1:0] RST_THR_LO   = 12'd0;
    localparam logic [SMP_W-1:0] RST_THR_HI   = 12'd4095;

    typedef enum logic [2:0] {
        REG_REF_MV    = 3'd0,
        REG_PITCH_LO  = 3'd1,
        REG_PITCH_MID = 3'd2,
        REG_PITCH_HI  = 3'd3,
        REG_THR_LO    = 3'd4,
        REG_THR_HI    = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILT,
        S_VOLT,
        S_PITCH_LOAD,
        S_PITCH_RUN,
        S_THR_LOAD,
        S_THR_RUN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [MV_W-1:0]  ref_mv;
        logic [SMP_W-1:0] pitch_lo;
        logic [SMP_W-1:0] pitch_mid;
        logic [SMP_W-1:0] pitch_hi;
        logic [SMP_W-1:0] thr_lo;
        logic [SMP_W-1:0] thr_hi;
    } t_cfg;

    typedef struct packed {
        logic                  in_take;
        logic [CHAN_IDX_W-1:0] chan;
        logic                  filt_we;
        logic                  volt_we;
        logic                  pitch_load;
        logic                  pitch_save;
        logic                  thr_load;
        logic                  thr_save;
        logic                  out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_ctrl_stat;

endpackage

[hdl/sac_divider.sv]
// sac_divider: restoring divider, one quotient bit per cycle.
// Depends on sac_pkg. Numerator must be below den * 2**QUOT_W.
`timescale 1ns / 1ps
module sac_divider
    import sac_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [SMP_W-1:0]  i_den,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     r_rem;
    logic [NUM_W-1:0]     r_dsh;
    logic [QUOT_W-1:0]    r_quot;
    logic                 w_ge;

    assign w_ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= NUM_W'(i_den) << (QUOT_W - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? (r_rem - r_dsh) : r_rem;
            r_dsh  <= r_dsh >> 1;
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[hdl/sac_regs.sv]
// sac_regs: APB register file holding reference and calibration points.
// Depends on sac_pkg.
`timescale 1ns / 1ps
module sac_regs
    import sac_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_mv    <= RST_REF_MV;
            r_cfg.pitch_lo  <= RST_PITCH_LO;
            r_cfg.pitch_mid <= RST_PITCH_MID;
            r_cfg.pitch_hi  <= RST_PITCH_HI;
            r_cfg.thr_lo    <= RST_THR_LO;
            r_cfg.thr_hi    <= RST_THR_HI;
        end else if (w_wr) begin
            case (w_idx)
                REG_REF_MV:    r_cfg.ref_mv    <= pwdata[MV_W-1:0];
                REG_PITCH_LO:  r_cfg.pitch_lo  <= pwdata[SMP_W-1:0];
                REG_PITCH_MID: r_cfg.pitch_mid <= pwdata[SMP_W-1:0];
                REG_PITCH_HI:  r_cfg.pitch_hi  <= pwdata[SMP_W-1:0];
                REG_THR_LO:    r_cfg.thr_lo    <= pwdata[SMP_W-1:0];
                REG_THR_HI:    r_cfg.thr_hi    <= pwdata[SMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_REF_MV:    prdata = APB_DATA_W'(r_cfg.ref_mv);
            REG_PITCH_LO:  prdata = APB_DATA_W'(r_cfg.pitch_lo);
            REG_PITCH_MID: prdata = APB_DATA_W'(r_cfg.pitch_mid);
            REG_PITCH_HI:  prdata = APB_DATA_W'(r_cfg.pitch_hi);
            REG_THR_LO:    prdata = APB_DATA_W'(r_cfg.thr_lo);
            REG_THR_HI:    prdata = APB_DATA_W'(r_cfg.thr_hi);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/sac_ctrl.sv]
// sac_ctrl: sequencing state machine (filter sweep, two divisions, result hand-off).
// Depends on sac_pkg.
`timescale 1ns / 1ps
module sac_ctrl
    import sac_pkg::*;
#(
    parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_new_scan,
    output logic       o_in_ready,
    input  t_ctrl_stat i_stat,
    output t_ctrl_cmd  o_cmd
);

    localparam int CH_W = $clog2(CHANNEL_COUNT);

    t_state          r_state, n_state;
    logic [CH_W-1:0] r_chan, n_chan;
    logic            w_last;

    assign w_last = (r_chan == CH_W'(CHANNEL_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chan  <= '0;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
        end
    end

    always_comb begin
        n_state = r_state;
        n_chan  = r_chan;
        case (r_state)
            S_IDLE: begin
                n_chan = '0;
                if (i_in_valid) begin
                    n_state = i_new_scan ? S_FILT : S_PITCH_LOAD;
                end
            end
            S_FILT: n_state = S_VOLT;
            S_VOLT: begin
                if (w_last) begin
                    n_state = S_PITCH_LOAD;
                end else begin
                    n_state = S_FILT;
                    n_chan  = r_chan + 1'b1;
                end
            end
            S_PITCH_LOAD: n_state = S_PITCH_RUN;
            S_PITCH_RUN: begin
                if (i_stat.div_done) begin
                    n_state = S_THR_LOAD;
                end
            end
            S_THR_LOAD: n_state = S_THR_RUN;
            S_THR_RUN: begin
                if (i_stat.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.chan = CHAN_IDX_W'(r_chan);
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.in_take = i_in_valid;
            end
            S_FILT:       o_cmd.filt_we    = 1'b1;
            S_VOLT:       o_cmd.volt_we    = 1'b1;
            S_PITCH_LOAD: o_cmd.pitch_load = 1'b1;
            S_PITCH_RUN:  o_cmd.pitch_save = i_stat.div_done;
            S_THR_LOAD:   o_cmd.thr_load   = 1'b1;
            S_THR_RUN:    o_cmd.thr_save   = i_stat.div_done;
            S_DONE:       o_cmd.out_load   = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

[hdl/sac_datapath.sv]
// sac_datapath: sample latch, filter and voltage stores, band setup, divider, output register.
// Depends on sac_pkg and sac_divider.
`timescale 1ns / 1ps
module sac_datapath
    import sac_pkg::*;
#(
    parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  t_ctrl_cmd            i_cmd,
    output t_ctrl_stat           o_stat,
    input  logic [S_TDATA_W-1:0] i_in_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [M_TDATA_W-1:0] o_out_data
);

    localparam int CH_W = $clog2(CHANNEL_COUNT);

    logic [SMP_W-1:0] r_sample [STORE_MAX];
    logic [KEY_W-1:0] r_pins;
    logic [SMP_W-1:0] r_smooth [CHANNEL_COUNT];
    logic [MV_W-1:0]  r_mv     [CHANNEL_COUNT];

    logic [CH_W-1:0]       w_idx;
    logic [SMP_W-1:0]      w_old;
    logic [SMP_W-1:0]      w_smp;
    logic [SMP_W+2:0]      w_sum;
    logic [SMP_W-1:0]      w_filt;
    logic [MV_W+SMP_W-1:0] w_prod;

    logic [SMP_W-1:0]  w_diff;
    logic [SMP_W-1:0]  w_den;
    logic              w_neg;
    logic [NUM_W-1:0]  w_num;
    logic              r_neg;
    logic              w_div_done;
    logic [QUOT_W-1:0] w_quot;
    logic [PCT_W-1:0]  w_q8;
    logic [PCT_W-1:0]  r_pitch;
    logic [THR_W-1:0]  r_thr;

    logic [SMP_W-1:0] w_sm_all [STORE_MAX];
    logic [MV_W-1:0]  w_mv_all [STORE_MAX];
    logic             r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take) begin
            for (int k = 0; k < STORE_MAX; k++) begin
                r_sample[k] <= i_in_data[k*SMP_W +: SMP_W];
            end
            r_pins <= i_in_data[S_KEY_LSB +: KEY_W];
        end
    end

    // (4*old + 12*new)/16 == (old + 3*new) >> 2
    assign w_idx  = i_cmd.chan[CH_W-1:0];
    assign w_old  = r_smooth[w_idx];
    assign w_smp  = r_sample[i_cmd.chan];
    assign w_sum  = (SMP_W+3)'(w_old) + (SMP_W+3)'({w_smp, 1'b0}) + (SMP_W+3)'(w_smp);
    assign w_filt = w_sum[SMP_W+1:2];
    assign w_prod = (MV_W+SMP_W)'(i_cfg.ref_mv) * (MV_W+SMP_W)'(w_old);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNEL_COUNT; k++) begin
                r_smooth[k] <= '0;
                r_mv[k]     <= '0;
            end
        end else begin
            if (i_cmd.filt_we) begin
                r_smooth[w_idx] <= w_filt;
            end
            if (i_cmd.volt_we) begin
                r_mv[w_idx] <= w_prod[MV_W+SMP_W-1 -: MV_W];
            end
        end
    end

    // clamped bands divide 1/1 or 0/1 so every path goes through the divider
    always_comb begin
        w_diff = '0;
        w_den  = SMP_W'(1);
        w_neg  = 1'b0;
        if (!i_cmd.thr_load) begin
            if (r_smooth[0] < i_cfg.pitch_lo) begin
                w_diff = SMP_W'(1);
                w_neg  = 1'b1;
            end else if (r_smooth[0] < i_cfg.pitch_mid) begin
                w_diff = i_cfg.pitch_mid - r_smooth[0];
                w_den  = i_cfg.pitch_mid - i_cfg.pitch_lo;
                w_neg  = 1'b1;
            end else if (r_smooth[0] < i_cfg.pitch_hi) begin
                w_diff = r_smooth[0] - i_cfg.pitch_mid;
                w_den  = i_cfg.pitch_hi - i_cfg.pitch_mid;
            end else begin
                w_diff = SMP_W'(1);
            end
        end else begin
            if (r_smooth[1] < i_cfg.thr_lo) begin
                w_diff = '0;
            end else if (r_smooth[1] < i_cfg.thr_hi) begin
                w_diff = r_smooth[1] - i_cfg.thr_lo;
                w_den  = i_cfg.thr_hi - i_cfg.thr_lo;
            end else begin
                w_diff = SMP_W'(1);
            end
        end
    end

    assign w_num = NUM_W'(w_diff) * NUM_W'(PCT_FULL);

    sac_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.pitch_load | i_cmd.thr_load),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_q8 = PCT_W'(w_quot);

    always_ff @(posedge i_clk) begin
        if (i_cmd.pitch_load) begin
            r_neg <= w_neg;
        end
        if (i_cmd.pitch_save) begin
            r_pitch <= r_neg ? (PCT_W'(0) - w_q8) : w_q8;
        end
        if (i_cmd.thr_save) begin
            r_thr <= THR_W'(PCT_FULL) - THR_W'(w_quot);
        end
    end

    for (genvar k = 0; k < STORE_MAX; k++) begin : g_ch
        if (k < CHANNEL_COUNT) begin : g_used
            assign w_sm_all[k] = r_smooth[k];
            assign w_mv_all[k] = r_mv[k];
        end else begin : g_unused
            assign w_sm_all[k] = '0;
            assign w_mv_all[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {{M_PAD_W{1'b0}},
                           w_mv_all[3], w_mv_all[2], w_mv_all[1], w_mv_all[0],
                           w_sm_all[3], w_sm_all[2], w_sm_all[1], w_sm_all[0],
                           ~r_pins, r_thr, r_pitch};
        end
    end

    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = ~r_out_valid | i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

endmodule

[hdl/stick_axis_conditioner.sv]
// Stick axis conditioner, one item at a time. The filter sweep filters each channel,
// then does its voltage multiply; pitch and throttle each go through the shared
// 7-step restoring divider. The next item can be accepted in the cycle after the
// result enters the output register.
// Reset (i_rst_n low at a clock edge): registers to defaults; stores, tvalid cleared.
`timescale 1ns / 1ps
module stick_axis_conditioner
    import sac_pkg::*;
#(
    parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [11:0] sample_zero, [23:12] sample_one, [35:24] sample_two, [47:36] sample_three,
    // [48] first_key_pin, [49] second_key_pin, [55:50] zero
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] new_scan
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [7:0] pitch_percent, [14:8] throttle_percent, [16:15] key_mask,
    // [28:17] smoothed_zero, [40:29] smoothed_one, [52:41] smoothed_two,
    // [64:53] smoothed_three, [80:65] millivolts_zero, [96:81] millivolts_one,
    // [112:97] millivolts_two, [128:113] millivolts_three, [135:129] zero
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg       w_cfg;
    t_ctrl_cmd  w_cmd;
    t_ctrl_stat w_stat;

    sac_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sac_ctrl #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_new_scan (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sac_datapath #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule
